### rtl/fifo_with_priority_extract_defines.svh
`ifndef FIFO_WITH_PRIORITY_EXTRACT_DEFINES_SVH
`define FIFO_WITH_PRIORITY_EXTRACT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PQE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PQE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/pqe_pkg.sv
package pqe_pkg;

	localparam int DEPTH         = 16;
	localparam int PAYLOAD_BITS  = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int IDX_W         = $clog2(DEPTH);
	localparam int CNT_W         = $clog2(DEPTH + 1);

	localparam logic [1:0] KIND_PUSH    = 2'd0;
	localparam logic [1:0] KIND_POP     = 2'd1;
	localparam logic [1:0] KIND_EXTRACT = 2'd2;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic [PAYLOAD_BITS-1:0]  payload;
		logic [PRIORITY_BITS-1:0] priority_req;
	} cmd_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [PAYLOAD_BITS-1:0]  payload_out;
		logic [PRIORITY_BITS-1:0] priority_out;
		logic [CNT_W-1:0]         count;
	} result_t;

	typedef struct packed {
		logic [PAYLOAD_BITS-1:0]  pay;
		logic [PRIORITY_BITS-1:0] pri;
	} entry_t;

	// running best handed from cell to cell
	typedef struct packed {
		logic [PRIORITY_BITS-1:0] pri;
		logic [PAYLOAD_BITS-1:0]  pay;
		logic [IDX_W-1:0]         idx;
	} best_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic             shift_en;
		logic [IDX_W-1:0] sel_idx;
		logic [CNT_W-1:0] count;
	} cell_ctrl_t;

endpackage

### rtl/pqe_cell.sv
module pqe_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  pqe_pkg::cell_ctrl_t ctrl,
	input  pqe_pkg::entry_t   wr_data,
	input  pqe_pkg::entry_t   next_data,
	input  pqe_pkg::best_t    chain_in,
	output pqe_pkg::best_t    chain_out,
	output pqe_pkg::entry_t   data_out
);
	import pqe_pkg::*;

	entry_t entry_q;
	best_t  best_q;
	logic   occupied;
	logic   take_own;

	assign occupied = CNT_W'(IDX) < ctrl.count;
	// strict compare keeps ties with the entry nearer the head
	assign take_own = occupied && ((IDX == 0) || (entry_q.pri > chain_in.pri));

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && (ctrl.wr_idx == IDX_W'(IDX))) begin
			entry_q <= wr_data;
		end else if (ctrl.shift_en && (IDX_W'(IDX) >= ctrl.sel_idx)) begin
			entry_q <= next_data;
		end
	end

	always_ff @(posedge clk) begin
		if (take_own) begin
			best_q.pri <= entry_q.pri;
			best_q.pay <= entry_q.pay;
			best_q.idx <= IDX_W'(IDX);
		end else begin
			best_q <= chain_in;
		end
	end

	assign chain_out = best_q;
	assign data_out  = entry_q;

endmodule

### rtl/fifo_with_priority_extract.sv
// Priority queue over a chain of DEPTH entry cells, head in cell 0.
// Push, full push, empty pop/extract and no-op report done from idle; pop goes
// through shift; extract through scan, set by the best-priority wavefront that
// walks the cell chain one cell per cycle, then shift. busy stays high until done.
// Reset (arst_n low) clears the count and control; cell contents stay undefined.
// done is a one-cycle strobe; the receiver cannot stall it.
`include "fifo_with_priority_extract_defines.svh"

module fifo_with_priority_extract (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pqe_pkg::cmd_t    cmd,
	output logic             done,
	output pqe_pkg::result_t result
);
	import pqe_pkg::*;

	// control state
	state_t           state_q, state_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic             op_pop_q, op_pop_n;
	logic [IDX_W-1:0] scan_cnt_q, scan_cnt_n;
	logic             done_q, done_n;
	result_t          res_q, res_n;

	// cell chain
	cell_ctrl_t ctrl;
	entry_t     wr_data;
	entry_t     data_arr [DEPTH+1];
	best_t      chain_arr [DEPTH+1];

	logic accept;
	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	assign wr_data.pay = cmd.payload;
	assign wr_data.pri = cmd.priority_req;

	// cell 0 takes its own entry whenever it is occupied, so the chain head input is a don't-care
	assign chain_arr[0] = '0;
	// last cell shifts in a copy of itself; it lies beyond the count after a removal
	assign data_arr[DEPTH] = data_arr[DEPTH-1];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		pqe_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.wr_data  (wr_data),
			.next_data(data_arr[i+1]),
			.chain_in (chain_arr[i]),
			.chain_out(chain_arr[i+1]),
			.data_out (data_arr[i])
		);
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (count_q != '0)) begin
					if (cmd.kind == KIND_POP) begin
						state_n = ST_SHIFT;
					end else if (cmd.kind == KIND_EXTRACT) begin
						state_n = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				// stay in scan until the wavefront has reached the last cell
				if (scan_cnt_q == IDX_W'(DEPTH - 1)) begin
					state_n = ST_SHIFT;
				end
			end
			ST_SHIFT: state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	// outputs and datapath control
	always_comb begin
		count_n       = count_q;
		op_pop_n      = op_pop_q;
		scan_cnt_n    = scan_cnt_q;
		done_n        = 1'b0;
		res_n         = '0;
		res_n.count   = count_q;
		ctrl.wr_en    = 1'b0;
		ctrl.wr_idx   = count_q[IDX_W-1:0];
		ctrl.shift_en = 1'b0;
		ctrl.sel_idx  = '0;
		ctrl.count    = count_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.kind)
						KIND_PUSH: begin
							done_n = 1'b1;
							if (count_q == CNT_W'(DEPTH)) begin
								res_n.status = STATUS_FULL;
							end else begin
								ctrl.wr_en  = 1'b1;
								count_n     = count_q + CNT_W'(1);
								res_n.count = count_q + CNT_W'(1);
							end
						end
						KIND_POP, KIND_EXTRACT: begin
							if (count_q == '0) begin
								done_n       = 1'b1;
								res_n.status = STATUS_EMPTY;
							end else begin
								op_pop_n   = (cmd.kind == KIND_POP);
								scan_cnt_n = '0;
							end
						end
						default: begin
							// unused code: no-op, report count
							done_n = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				scan_cnt_n = scan_cnt_q + IDX_W'(1);
			end
			ST_SHIFT: begin
				ctrl.shift_en = 1'b1;
				done_n        = 1'b1;
				count_n       = count_q - CNT_W'(1);
				res_n.count   = count_q - CNT_W'(1);
				if (op_pop_q) begin
					ctrl.sel_idx       = '0;
					res_n.payload_out  = data_arr[0].pay;
					res_n.priority_out = data_arr[0].pri;
				end else begin
					ctrl.sel_idx       = chain_arr[DEPTH].idx;
					res_n.payload_out  = chain_arr[DEPTH].pay;
					res_n.priority_out = chain_arr[DEPTH].pri;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			op_pop_q   <= 1'b0;
			scan_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_n;
			count_q    <= count_n;
			op_pop_q   <= op_pop_n;
			scan_cnt_q <= scan_cnt_n;
			done_q     <= done_n;
		end
	end

	// result payload register, qualified by done
	always_ff @(posedge clk) begin
		res_q <= res_n;
	end

	assign done   = done_q;
	assign result = res_q;

	// checks
	`PQE_ASSERT_NOW(a_count_bound, done, result.count <= CNT_W'(DEPTH))
	`PQE_ASSERT_NEXT(a_full_drop, accept && (cmd.kind == KIND_PUSH) && (count_q == CNT_W'(DEPTH)), done && (result.status == STATUS_FULL) && (count_q == CNT_W'(DEPTH)))
	`PQE_ASSERT_NOW(a_empty_zero, done && (result.status == STATUS_EMPTY), (result.count == '0) && (result.payload_out == '0) && (result.priority_out == '0))
	`PQE_ASSERT_NEXT(a_shift_done, state_q == ST_SHIFT, done && (state_q == ST_IDLE))

endmodule

### dv/tb_fifo_with_priority_extract.sv
module tb_fifo_with_priority_extract;
	timeunit 1ns;
	timeprecision 1ps;

	import pqe_pkg::*;

	// kind 3 is unused by the block: it must behave as a no-op
	localparam logic [1:0] KIND_NOP = 2'd3;

	// slowest item is an extract; drain margin after last result
	localparam int DRAIN_CYCLES = DEPTH + 8;
	// ~1600 items, each at worst an extract plus the longest gap, stay well under this limit
	localparam int CYCLE_LIMIT  = 400000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    done;
	result_t result;

	// predictor state: entries held in order, head at index 0
	entry_t  held_entries[$];
	result_t expected_results[$];

	fifo_with_priority_extract i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// ------------------------------------------------------------------
	// Clock, reset and watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	int unsigned cycle_cnt = 0;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still outstanding",
				cycle_cnt, expected_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Queue predictor
	// ------------------------------------------------------------------
	function automatic result_t apply_cmd(input cmd_t c);
		result_t r;
		entry_t  e;
		int      sel;
		r = '0;
		r.status = STATUS_DONE;
		case (c.kind)
			KIND_PUSH: begin
				if (held_entries.size() >= DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					e.pay = c.payload;
					e.pri = c.priority_req;
					held_entries.push_back(e);
				end
			end
			KIND_POP, KIND_EXTRACT: begin
				if (held_entries.size() == 0) begin
					r.status = STATUS_EMPTY;
				end else begin
					sel = 0;
					// strict compare keeps ties on the entry nearest the head
					if (c.kind == KIND_EXTRACT) begin
						for (int i = 1; i < held_entries.size(); i++) begin
							if (held_entries[i].pri > held_entries[sel].pri)
								sel = i;
						end
					end
					r.payload_out  = held_entries[sel].pay;
					r.priority_out = held_entries[sel].pri;
					held_entries.delete(sel);
				end
			end
			default: ;
		endcase
		r.count = CNT_W'(held_entries.size());
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checker and coverage tallies
	// ------------------------------------------------------------------
	int unsigned fail_cnt      = 0;
	int unsigned checked_cnt   = 0;
	int unsigned push_cnt      = 0;
	int unsigned full_drop_cnt = 0;
	int unsigned pop_cnt       = 0;
	int unsigned extract_cnt   = 0;
	int unsigned empty_cnt     = 0;
	int unsigned nop_cnt       = 0;
	int unsigned peak_count    = 0;

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n) begin
			// compare first: a new item may be taken on the edge that ends a result
			if (done) begin
				if (expected_results.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: result with nothing expected: status %0d payload %h pri %h count %0d",
							$realtime, result.status, result.payload_out,
							result.priority_out, result.count);
				end else begin
					exp_r = expected_results.pop_front();
					checked_cnt++;
					if (result.status !== exp_r.status ||
						result.payload_out !== exp_r.payload_out ||
						result.priority_out !== exp_r.priority_out ||
						result.count !== exp_r.count) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("%0t: mismatch exp status %0d payload %h pri %h count %0d, got status %0d payload %h pri %h count %0d",
								$realtime, exp_r.status, exp_r.payload_out,
								exp_r.priority_out, exp_r.count, result.status,
								result.payload_out, result.priority_out, result.count);
					end
				end
			end
			if (start && !busy) begin
				exp_r = apply_cmd(cmd);
				expected_results.push_back(exp_r);
				case (cmd.kind)
					KIND_PUSH:    push_cnt++;
					KIND_POP:     pop_cnt++;
					KIND_EXTRACT: extract_cnt++;
					default:      nop_cnt++;
				endcase
				if (exp_r.status == STATUS_FULL)
					full_drop_cnt++;
				if (exp_r.status == STATUS_EMPTY)
					empty_cnt++;
				if (held_entries.size() > peak_count)
					peak_count = held_entries.size();
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	bit gaps_on = 1'b1;

	// one item: optional idle gap, then hold start until the block takes it
	task automatic send_cmd(input logic [1:0] kind, input logic [PAYLOAD_BITS-1:0] pay,
			input logic [PRIORITY_BITS-1:0] pri);
		int gap;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 99) < 20) begin
			// one gap in four is a long one; the rest are short
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start            <= 1'b1;
		cmd.kind         <= kind;
		cmd.payload      <= pay;
		cmd.priority_req <= pri;
		do @(posedge clk); while (busy);
	endtask

	// random item with a push bias; narrow priorities force many ties
	task automatic send_random(input int push_pct, input bit narrow_pri);
		int                       roll;
		logic [1:0]               kind;
		logic [PRIORITY_BITS-1:0] pri;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			kind = KIND_NOP;
		else if (roll < 3 + push_pct)
			kind = KIND_PUSH;
		else if ($urandom_range(0, 1) == 0)
			kind = KIND_POP;
		else
			kind = KIND_EXTRACT;
		pri = narrow_pri ? PRIORITY_BITS'($urandom_range(0, 3)) : PRIORITY_BITS'($urandom());
		send_cmd(kind, PAYLOAD_BITS'($urandom()), pri);
	endtask

	// removal and no-op on an empty queue
	task automatic test_empty_queue();
		send_cmd(KIND_POP, 16'hFFFF, 8'hFF);
		send_cmd(KIND_EXTRACT, 16'hFFFF, 8'hFF);
		send_cmd(KIND_NOP, 16'hFFFF, 8'hFF);
	endtask

	// fill to DEPTH with extreme tags and priorities, then overflow
	task automatic test_fill_and_overflow();
		logic [PRIORITY_BITS-1:0] pri;
		for (int i = 0; i < DEPTH; i++) begin
			// two equal maxima: extract must take the earlier one first
			if (i == 3 || i == 9)
				pri = '1;
			else if (i == 0)
				pri = '0;
			else
				pri = PRIORITY_BITS'(8'h10 + i);
			send_cmd(KIND_PUSH, PAYLOAD_BITS'(16'h1111 * i), pri);
		end
		send_cmd(KIND_PUSH, 16'hDEAD, 8'hFF);
		send_cmd(KIND_NOP, 16'h0000, 8'h00);
	endtask

	// tie breaking across the two maxima, then a plain pop from the head
	task automatic test_extract_order();
		send_cmd(KIND_EXTRACT, 16'h0000, 8'h00);
		send_cmd(KIND_EXTRACT, 16'h0000, 8'h00);
		send_cmd(KIND_POP, 16'h0000, 8'h00);
	endtask

	// phases that swing between filling, draining and balanced traffic
	task automatic test_random_traffic(input int n_items);
		int left;
		int push_pct;
		bit narrow_pri;
		left = 0;
		push_pct = 50;
		narrow_pri = 1'b0;
		for (int i = 0; i < n_items; i++) begin
			if (left == 0) begin
				left = $urandom_range(20, 60);
				case ($urandom_range(0, 2))
					0:       push_pct = 85;
					1:       push_pct = 20;
					default: push_pct = 48;
				endcase
				narrow_pri = ($urandom_range(0, 2) == 0);
			end
			left--;
			send_random(push_pct, narrow_pri);
		end
	endtask

	// back-to-back items with no idle cycles at all
	task automatic test_back_to_back(input int n_items);
		gaps_on = 1'b0;
		test_random_traffic(n_items);
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_queue();
		test_fill_and_overflow();
		test_extract_order();
		test_random_traffic(1000);
		test_back_to_back(350);
		test_random_traffic(226);

		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		// catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d pushes (%0d dropped on full), %0d pops, %0d extracts, %0d no-ops",
			push_cnt, full_drop_cnt, pop_cnt, extract_cnt, nop_cnt);
		$display("%0d removals hit an empty queue, peak occupancy %0d of %0d, %0d results checked, %0d failures",
			empty_cnt, peak_count, DEPTH, checked_cnt, fail_cnt);
		if (fail_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
